>>> hdl/brtc_pkg.sv
`default_nettype none
package brtc_pkg;

  // command codes
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // calendar constants
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned DAYS_PER_ERA = 146097;
  localparam int unsigned CIVIL_SHIFT  = 719468;
  // offset from a March-based day count for years counted from 1600 to Unix epoch days
  localparam int unsigned DAY_OFS      = 135081;
  localparam int unsigned YEAR_LO      = 2000;
  localparam int unsigned YEAR_CENT    = 2100;
  localparam int unsigned YEAR_HI      = YEAR_LO + 199;

  // reset value of the validity threshold
  localparam logic [33:0] MIN_EPOCH_RST = 34'd946684800;

  // pipeline depth
  localparam int unsigned STAGES = 13;

  // reciprocals for constant division: q = (x * R) >> S
  localparam int unsigned S675   = 37;
  localparam logic [27:0] R675   = 28'(((64'd1 << S675) + 64'd674) / 64'd675);
  localparam int unsigned S3600  = 29;
  localparam logic [17:0] R3600  = 18'(((64'd1 << S3600) + 64'd3599) / 64'd3600);
  localparam int unsigned S60    = 18;
  localparam logic [12:0] R60    = 13'(((64'd1 << S60) + 64'd59) / 64'd60);
  localparam int unsigned SERA   = 38;
  localparam logic [20:0] RERA   = 21'(((64'd1 << SERA) + 64'd146096) / 64'd146097);
  localparam int unsigned S1460  = 29;
  localparam logic [18:0] R1460  = 19'(((64'd1 << S1460) + 64'd1459) / 64'd1460);
  localparam int unsigned S36524 = 34;
  localparam logic [18:0] R36524 = 19'(((64'd1 << S36524) + 64'd36523) / 64'd36524);
  localparam int unsigned S365   = 27;
  localparam logic [18:0] R365   = 19'(((64'd1 << S365) + 64'd364) / 64'd365);
  localparam int unsigned S100A  = 16;
  localparam logic [9:0]  R100A  = 10'(((64'd1 << S100A) + 64'd99) / 64'd100);
  localparam int unsigned S100B  = 17;
  localparam logic [10:0] R100B  = 11'(((64'd1 << S100B) + 64'd99) / 64'd100);
  localparam int unsigned S153   = 19;
  localparam logic [11:0] R153   = 12'(((64'd1 << S153) + 64'd152) / 64'd153);
  localparam int unsigned S5     = 15;
  localparam logic [12:0] R5     = 13'(((64'd1 << S5) + 64'd4) / 64'd5);
  localparam int unsigned S10    = 11;
  localparam logic [7:0]  R10    = 8'(((64'd1 << S10) + 64'd9) / 64'd10);
  localparam int unsigned S7     = 21;
  localparam logic [18:0] R7     = 19'(((64'd1 << S7) + 64'd6) / 64'd7);

  // control from the handshake logic to the datapath
  typedef struct packed {
    logic en;
    logic in_valid;
  } pipe_ctl_t;

  // one result beat
  typedef struct packed {
    logic [33:0] epoch_seconds;
    logic        time_ok;
    logic [7:0]  sec_out;
    logic [7:0]  min_out;
    logic [7:0]  hour_out;
    logic [2:0]  weekday_out;
    logic [7:0]  date_out;
    logic [7:0]  month_out;
    logic [7:0]  year_out;
  } result_t;

  // bcd byte to binary, nibbles at face value
  function automatic logic [7:0] bcd_in8(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // binary below 100 to bcd byte
  function automatic logic [7:0] bcd_out8(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'((16'(v) * 16'(R10)) >> S10);
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

>>> hdl/brtc_pipe.sv
`default_nettype none
module brtc_pipe import brtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pipe_ctl_t   ctl,
  input  wire logic        command,
  input  wire logic [7:0]  sec_byte,
  input  wire logic [7:0]  min_byte,
  input  wire logic [7:0]  hour_byte,
  input  wire logic [7:0]  date_byte,
  input  wire logic [7:0]  month_byte,
  input  wire logic [7:0]  year_byte,
  input  wire logic [33:0] epoch_in,
  input  wire logic [33:0] min_epoch,
  output logic             out_valid,
  output result_t          result
);

  typedef struct packed {
    logic        cmd;
    // encode path
    logic [33:0] t;
    logic [17:0] days;
    logic [16:0] rem;
    logic [19:0] z;
    logic [17:0] x7;
    logic [2:0]  era;
    logic [4:0]  hh;
    logic [14:0] wq;
    logic [2:0]  wd;
    logic [17:0] doe;
    logic [11:0] r2;
    logic [5:0]  mn;
    logic [5:0]  sc;
    logic [6:0]  qa;
    logic [2:0]  qb;
    logic        qc;
    logic [17:0] v;
    logic [8:0]  yoe;
    logic [2:0]  yc;
    logic [17:0] y365;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [4:0]  d;
    logic [3:0]  m;
    logic        ok_enc;
    logic        cent;
    logic [6:0]  yy;
    // decode path
    logic [6:0]  ds;
    logic [6:0]  dm;
    logic [5:0]  dh;
    logic [5:0]  dd;
    logic [4:0]  mo;
    logic [9:0]  mt;
    logic [9:0]  u;
    logic [2:0]  uc;
    logic [17:0] hms;
    logic [16:0] ddays;
    logic [33:0] esec;
    logic        ok_dec;
    // result
    result_t     res;
  } st_t;

  st_t              st [0:STAGES-1];
  st_t              nx [0:STAGES-1];
  logic [STAGES-1:0] vld;
  logic [4:0]       mk;
  logic [7:0]       yb;

  // stage logic, built from constant multiplies
  always_comb begin
    yb = 8'd0;
    mk = 5'd0;
    // stage 0: day count quotient, bcd decode of the register bytes
    nx[0]      = '0;
    nx[0].cmd  = command;
    nx[0].t    = epoch_in;
    nx[0].days = 18'((64'(epoch_in >> 7) * 64'(R675)) >> S675);
    nx[0].ds   = 7'(bcd_in8({1'b0, sec_byte[6:0]}));
    nx[0].dm   = 7'(bcd_in8({1'b0, min_byte[6:0]}));
    nx[0].dh   = 6'(bcd_in8({2'b0, hour_byte[5:0]}));
    nx[0].dd   = 6'(bcd_in8({2'b0, date_byte[5:0]}));
    nx[0].mo   = 5'(bcd_in8({3'b0, month_byte[4:0]}));
    yb         = bcd_in8(year_byte);
    mk         = (nx[0].mo > 5'd2) ? nx[0].mo - 5'd3 : nx[0].mo + 5'd9;
    nx[0].mt   = 10'(((64'(mk) * 64'd153 + 64'd2) * 64'(R5)) >> S5);
    nx[0].u    = 10'(16'(yb) + 16'd400 + (month_byte[7] ? 16'd100 : 16'd0)
                     - ((nx[0].mo <= 5'd2) ? 16'd1 : 16'd0));

    // stage 1: seconds of day, shifted day number, year/100
    nx[1]     = st[0];
    nx[1].rem = 17'(64'(st[0].t) - 64'(st[0].days) * 64'(SECS_PER_DAY));
    nx[1].z   = 20'(32'(st[0].days) + CIVIL_SHIFT);
    nx[1].x7  = st[0].days + 18'd4;
    nx[1].uc  = 3'((32'(st[0].u) * 32'(R100B)) >> S100B);
    nx[1].hms = 18'(32'(st[0].dh) * 32'd3600 + 32'(st[0].dm) * 32'd60 + 32'(st[0].ds));

    // stage 2: era, hours, weekday quotient, decoded day count
    nx[2]       = st[1];
    nx[2].era   = 3'((64'(st[1].z) * 64'(RERA)) >> SERA);
    nx[2].hh    = 5'((64'(st[1].rem) * 64'(R3600)) >> S3600);
    nx[2].wq    = 15'((64'(st[1].x7) * 64'(R7)) >> S7);
    nx[2].ddays = 17'(32'(st[1].u) * 32'd365 + 32'(st[1].u >> 2) - 32'(st[1].uc)
                      + 32'(st[1].uc >> 2) + 32'(st[1].mt) + 32'(st[1].dd) - DAY_OFS);

    // stage 3: day of era, seconds of hour, weekday, decoded seconds
    nx[3]      = st[2];
    nx[3].doe  = 18'(32'(st[2].z) - 32'(st[2].era) * DAYS_PER_ERA);
    nx[3].r2   = 12'(32'(st[2].rem) - 32'(st[2].hh) * 32'd3600);
    nx[3].wd   = 3'(32'(st[2].x7) - 32'(st[2].wq) * 32'd7 + 32'd1);
    nx[3].esec = 34'(64'(st[2].ddays) * 64'(SECS_PER_DAY) + 64'(st[2].hms));

    // stage 4: leap corrections, minutes, decode threshold
    nx[4]        = st[3];
    nx[4].qa     = 7'((64'(st[3].doe) * 64'(R1460)) >> S1460);
    nx[4].qb     = 3'((64'(st[3].doe) * 64'(R36524)) >> S36524);
    nx[4].qc     = (st[3].doe == 18'(DAYS_PER_ERA - 1));
    nx[4].mn     = 6'((32'(st[3].r2) * 32'(R60)) >> S60);
    nx[4].ok_dec = (st[3].esec >= min_epoch);

    // stage 5: leap-adjusted day of era, seconds
    nx[5]    = st[4];
    nx[5].v  = st[4].doe - 18'(st[4].qa) + 18'(st[4].qb) - 18'(st[4].qc);
    nx[5].sc = 6'(st[4].r2 - 12'(st[4].mn) * 12'd60);

    // stage 6: year of era
    nx[6]     = st[5];
    nx[6].yoe = 9'((64'(st[5].v) * 64'(R365)) >> S365);

    // stage 7: year terms
    nx[7]      = st[6];
    nx[7].yc   = 3'((32'(st[6].yoe) * 32'(R100A)) >> S100A);
    nx[7].y365 = 18'(st[6].yoe) * 18'd365;

    // stage 8: day of year from march
    nx[8]     = st[7];
    nx[8].doy = 9'(st[7].doe - (st[7].y365 + 18'(st[7].yoe >> 2) - 18'(st[7].yc)));

    // stage 9: month index from march
    nx[9]    = st[8];
    nx[9].mp = 4'(((32'(st[8].doy) * 32'd5 + 32'd2) * 32'(R153)) >> S153);

    // stage 10: day of month and calendar month
    nx[10]   = st[9];
    nx[10].d = 5'(32'(st[9].doy) - (((32'(st[9].mp) * 32'd153 + 32'd2) * 32'(R5)) >> S5)
                  + 32'd1);
    nx[10].m = (st[9].mp < 4'd10) ? st[9].mp + 4'd3 : st[9].mp - 4'd9;

    // stage 11: full year, range check, century split
    nx[11]        = st[10];
    begin
      logic [11:0] y;
      y = 12'(st[10].yoe) + 12'(st[10].era) * 12'd400 + ((st[10].m <= 4'd2) ? 12'd1 : 12'd0);
      nx[11].ok_enc = (y >= 12'(YEAR_LO)) && (y <= 12'(YEAR_HI));
      nx[11].cent   = (y >= 12'(YEAR_CENT));
      nx[11].yy     = nx[11].cent ? 7'(y - 12'(YEAR_CENT)) : 7'(y - 12'(YEAR_LO));
    end

    // stage 12: result formatting per command
    nx[12]     = st[11];
    nx[12].res = '0;
    if (st[11].cmd == CMD_DECODE) begin
      nx[12].res.epoch_seconds = st[11].esec;
      nx[12].res.time_ok       = st[11].ok_dec;
    end else if (st[11].ok_enc) begin
      nx[12].res.time_ok     = 1'b1;
      nx[12].res.sec_out     = bcd_out8(7'(st[11].sc));
      nx[12].res.min_out     = bcd_out8(7'(st[11].mn));
      nx[12].res.hour_out    = bcd_out8(7'(st[11].hh));
      nx[12].res.weekday_out = st[11].wd;
      nx[12].res.date_out    = bcd_out8(7'(st[11].d));
      nx[12].res.month_out   = bcd_out8(7'(st[11].m)) | {st[11].cent, 7'd0};
      nx[12].res.year_out    = bcd_out8(st[11].yy);
    end
  end

  // stage registers, all advance together
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      st <= nx;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[STAGES-2:0], ctl.in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];
  assign result    = st[STAGES-1].res;

endmodule
`default_nettype wire

>>> hdl/bcd_rtc_epoch_converter.sv
`default_nettype none
// Converts between the seven BCD registers of a real-time clock and Unix epoch
// seconds. A beat with tuser = 0 decodes the register bytes into epoch seconds
// and flags them valid when they reach min_valid_epoch; tuser = 1 encodes
// epoch_in into register bytes, flagging (and zeroing) years outside
// 2000..2199. The datapath is a 13-stage pipeline of constant multiplies; one
// beat is accepted every cycle while the output side keeps up, and a stall on
// m_tready freezes the whole pipeline. min_valid_epoch resets to 946684800 and
// must be written by the user on the cfg channel only while the block is idle;
// the block itself does not enforce this.
module bcd_rtc_epoch_converter import brtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // cfg write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [33:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // sec_byte, min_byte, hour_byte, weekday_byte, date_byte, month_byte,
  // year_byte, epoch_in, zero pad
  input  wire logic [95:0] s_tdata,
  // command
  input  wire logic [0:0]  s_tuser,
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // epoch_seconds, sec_out, min_out, hour_out, weekday_out, date_out,
  // month_out, year_out, zero pad
  output logic [87:0]      m_tdata,
  // time_ok
  output logic [0:0]       m_tuser
);

  logic [33:0] min_valid_epoch;
  pipe_ctl_t   ctl;
  result_t     res;
  logic        out_valid;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid_epoch <= MIN_EPOCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_valid_epoch <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // pipeline advances whenever the output stage is free or being taken
  assign ctl.en       = !out_valid || m_tready;
  assign ctl.in_valid = s_tvalid;
  assign s_tready     = ctl.en;

  brtc_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .command    (s_tuser[0]),
    .sec_byte   (s_tdata[7:0]),
    .min_byte   (s_tdata[15:8]),
    .hour_byte  (s_tdata[23:16]),
    .date_byte  (s_tdata[39:32]),
    .month_byte (s_tdata[47:40]),
    .year_byte  (s_tdata[55:48]),
    .epoch_in   (s_tdata[89:56]),
    .min_epoch  (min_valid_epoch),
    .out_valid  (out_valid),
    .result     (res)
  );

  // output beat packing
  assign m_tvalid = out_valid;
  assign m_tuser  = res.time_ok;
  assign m_tdata  = {3'd0, res.year_out, res.month_out, res.date_out, res.weekday_out,
                     res.hour_out, res.min_out, res.sec_out, res.epoch_seconds};

`ifndef NO_ASSERTIONS
  // a decoded epoch never comes with register bytes
  a_dec_no_bytes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:0] != 34'd0) |-> (m_tdata[84:34] == 51'd0))
    else $error("decode beat carries register bytes");

  // a good encode always has a weekday
  a_enc_weekday: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:0] == 34'd0) && m_tuser[0] |-> (m_tdata[60:58] != 3'd0))
    else $error("encode beat without weekday");

  // a rejected encode gives zero bytes
  a_enc_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:0] == 34'd0) && !m_tuser[0] |-> (m_tdata[84:34] == 51'd0))
    else $error("rejected encode carries bytes");
`endif

endmodule
`default_nettype wire
